// ===== sv/dec_pkg.sv =====
package dec_pkg;
  localparam int WORDS = 4;
  localparam int WORD_BITS = 64;
  localparam int IDX_W = 3;

  typedef enum logic [2:0] {
    CLS_IDENT   = 3'd0,
    CLS_SGL_A   = 3'd1,
    CLS_SGL_B   = 3'd2,
    CLS_DBL_AA  = 3'd3,
    CLS_DBL_BB  = 3'd4,
    CLS_DBL_AB  = 3'd5,
    CLS_HIGHER  = 3'd6,
    CLS_UNUSED  = 3'd7
  } cls_t;

  typedef struct packed {
    logic       spin;
    logic [7:0] orb;
    logic       par;
  } slot_t;

  typedef struct packed {
    logic [9:0] diff;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] da;
    logic [1:0] db;
    slot_t      s0;
    slot_t      s1;
    slot_t      s2;
    slot_t      s3;
  } summ_t;

  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n = n + 7'(x[i]);
    return n;
  endfunction

  function automatic logic [1:0] sat3(input logic [1:0] a, input logic [6:0] b);
    logic [7:0] s;
    s = 8'(a) + 8'(b);
    return (s > 8'd3) ? 2'd3 : s[1:0];
  endfunction

  function automatic logic [5:0] low_idx(input logic [63:0] x);
    logic [5:0] p;
    p = 6'd63;
    for (int i = 63; i >= 0; i--) if (x[i]) p = 6'(i);
    return p;
  endfunction
endpackage

// ===== sv/determinant_excitation_classifier.sv =====
// One result per pair, queued from its last word, then popped into output registers.
// One word beat per cycle unless the queue is full; the front scan of popcounts and
// priority encoders runs one word per cycle, the back classifies one pair per cycle
// unless stalled. A two-entry queue between front and back decouples their stalls.
// Reset: synchronous active-low rst_n clears word index, parities, counts and queue.
module determinant_excitation_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_bra_alpha_word,
  input  logic [63:0] in_bra_beta_word,
  input  logic [63:0] in_ket_alpha_word,
  input  logic [63:0] in_ket_beta_word,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_excitation_class,
  output logic [8:0]  out_excitation_distance,
  output logic [7:0]  out_create_first,
  output logic [7:0]  out_destroy_first,
  output logic [7:0]  out_create_second,
  output logic [7:0]  out_destroy_second,
  output logic        out_sign_negative
);
  import dec_pkg::*;

  logic  push, full, pop, nempty;
  summ_t wdata, rdata;

  dec_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_bra_alpha_word, .in_bra_beta_word, .in_ket_alpha_word, .in_ket_beta_word,
    .in_last_word, .q_push(push), .q_data(wdata), .q_full(full)
  );

  dec_queue u_queue (
    .clk, .rst_n, .push, .wdata, .full, .pop, .nempty, .rdata
  );

  dec_back u_back (
    .clk, .rst_n, .q_nempty(nempty), .q_data(rdata), .q_pop(pop),
    .out_valid, .out_ready, .out_excitation_class, .out_excitation_distance,
    .out_create_first, .out_destroy_first, .out_create_second,
    .out_destroy_second, .out_sign_negative
  );
endmodule

// ===== sv/dec_front.sv =====
module dec_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_bra_alpha_word,
  input  logic [63:0]        in_bra_beta_word,
  input  logic [63:0]        in_ket_alpha_word,
  input  logic [63:0]        in_ket_beta_word,
  input  logic               in_last_word,
  output logic               q_push,
  output dec_pkg::summ_t     q_data,
  input  logic               q_full
);
  import dec_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic             pa_r, pb_r;
  summ_t            acc_r, nxt;
  logic             fire, last;
  logic [63:0]      ua, ub;
  logic [6:0]       pop_ka, pop_kb;

  function automatic void grab2(input logic [63:0] bits, input logic spin,
                                input logic [63:0] ketw, input logic [1:0] used,
                                input logic parb, input logic [IDX_W-1:0] wi,
                                inout slot_t sa, inout slot_t sb);
    logic [63:0] b;
    logic [5:0]  p;
    logic [1:0]  u;
    logic [6:0]  pc;
    slot_t       s;
    b = bits;
    u = used;
    for (int k = 0; k < 2; k++) begin
      if (u < 2'd2 && b != '0) begin
        p = low_idx(b);
        s.spin = spin;
        s.orb = {wi[1:0], p};
        pc = pop64(ketw & ((64'd1 << p) - 64'd1));
        s.par = parb ^ pc[0];
        if (u == 2'd0) sa = s; else sb = s;
        u = u + 2'd1;
        b[p] = 1'b0;
      end
    end
  endfunction

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;
  assign last = in_last_word || (idx_r >= IDX_W'(WORDS - 1));
  assign ua = in_bra_alpha_word ^ in_ket_alpha_word;
  assign ub = in_bra_beta_word ^ in_ket_beta_word;
  assign pop_ka = pop64(in_ket_alpha_word);
  assign pop_kb = pop64(in_ket_beta_word);

  always_comb begin
    logic [1:0] u;
    nxt = acc_r;
    nxt.diff = acc_r.diff + 10'(pop64(ua)) + 10'(pop64(ub));
    u = sat3(acc_r.ca, 7'(acc_r.cb));
    grab2(ua & in_bra_alpha_word, 1'b0, in_ket_alpha_word, u, pa_r, idx_r,
          nxt.s0, nxt.s1);
    nxt.ca = sat3(acc_r.ca, pop64(ua & in_bra_alpha_word));
    u = sat3(nxt.ca, 7'(acc_r.cb));
    if (u > 2'd2) u = 2'd2;
    grab2(ub & in_bra_beta_word, 1'b1, in_ket_beta_word, u, pb_r, idx_r,
          nxt.s0, nxt.s1);
    nxt.cb = sat3(acc_r.cb, pop64(ub & in_bra_beta_word));
    u = sat3(acc_r.da, 7'(acc_r.db));
    grab2(ua & in_ket_alpha_word, 1'b0, in_ket_alpha_word, u, pa_r, idx_r,
          nxt.s2, nxt.s3);
    nxt.da = sat3(acc_r.da, pop64(ua & in_ket_alpha_word));
    u = sat3(nxt.da, 7'(acc_r.db));
    if (u > 2'd2) u = 2'd2;
    grab2(ub & in_ket_beta_word, 1'b1, in_ket_beta_word, u, pb_r, idx_r,
          nxt.s2, nxt.s3);
    nxt.db = sat3(acc_r.db, pop64(ub & in_ket_beta_word));
  end

  assign q_push = fire && last;
  assign q_data = nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last)) begin
      idx_r <= '0;
      pa_r  <= 1'b0;
      pb_r  <= 1'b0;
      acc_r <= '0;
    end else if (fire) begin
      idx_r <= idx_r + IDX_W'(1);
      pa_r  <= pa_r ^ pop_ka[0];
      pb_r  <= pb_r ^ pop_kb[0];
      acc_r <= nxt;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(WORDS - 1)) else $error("word index past end");
  a_push_fire: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> fire) else $error("push without beat");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (idx_r == '0 && acc_r.diff == '0)) else $error("no clear");
endmodule

// ===== sv/dec_queue.sv =====
module dec_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dec_pkg::summ_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nempty,
  output dec_pkg::summ_t rdata
);
  import dec_pkg::*;

  summ_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign nempty = cnt_r != 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !nempty)) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("count out of range");
endmodule

// ===== sv/dec_back.sv =====
module dec_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nempty,
  input  dec_pkg::summ_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_excitation_class,
  output logic [8:0]     out_excitation_distance,
  output logic [7:0]     out_create_first,
  output logic [7:0]     out_destroy_first,
  output logic [7:0]     out_create_second,
  output logic [7:0]     out_destroy_second,
  output logic           out_sign_negative
);
  import dec_pkg::*;

  logic       vld_r;
  cls_t       cls;
  logic [7:0] c1, d1, c2, d2;
  logic       sg;
  summ_t      s;

  assign s = q_data;
  assign q_pop = q_nempty && (!vld_r || out_ready);

  always_comb begin
    logic [2:0] sum;
    slot_t ac, bc, ad, bd;
    cls = CLS_HIGHER;
    c1 = '0; d1 = '0; c2 = '0; d2 = '0; sg = 1'b0;
    sum = 3'(s.ca) + 3'(s.cb);
    ac = s.s0.spin ? s.s1 : s.s0;
    bc = s.s0.spin ? s.s0 : s.s1;
    ad = s.s2.spin ? s.s3 : s.s2;
    bd = s.s2.spin ? s.s2 : s.s3;
    if (s.ca == 0 && s.cb == 0 && s.da == 0 && s.db == 0) begin
      cls = CLS_IDENT;
    end else if (s.ca != s.da || s.cb != s.db || sum > 3'd2) begin
      cls = CLS_HIGHER;
    end else if (sum == 3'd1) begin
      cls = (s.ca == 2'd1) ? CLS_SGL_A : CLS_SGL_B;
      c1 = s.s0.orb; d1 = s.s2.orb;
      sg = s.s0.par ^ s.s2.par;
    end else if (s.ca == 2'd1) begin
      cls = CLS_DBL_AB;
      c1 = ac.orb; c2 = bc.orb; d1 = ad.orb; d2 = bd.orb;
      sg = s.s0.par ^ s.s1.par ^ s.s2.par ^ s.s3.par;
    end else begin
      cls = (s.ca == 2'd2) ? CLS_DBL_AA : CLS_DBL_BB;
      c1 = s.s0.orb; c2 = s.s1.orb; d1 = s.s2.orb; d2 = s.s3.orb;
      sg = s.s0.par ^ s.s1.par ^ s.s2.par ^ s.s3.par
         ^ (d1 < c2) ^ (c1 < c2) ^ (d1 < d2) ^ (c1 < d2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (q_pop) vld_r <= 1'b1;
    else if (out_ready) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_excitation_class    <= cls;
      out_excitation_distance <= s.diff[9:1];
      out_create_first        <= c1;
      out_destroy_first       <= d1;
      out_create_second       <= c2;
      out_destroy_second      <= d2;
      out_sign_negative       <= sg;
    end
  end

  assign out_valid = vld_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_excitation_class))
    else $error("result changed under stall");
  a_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_excitation_class != CLS_UNUSED) else $error("bad class");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid) else $error("pop lost");
endmodule

// ===== verif/tb_determinant_excitation_classifier.sv =====
`timescale 1ns / 1ps

module tb_determinant_excitation_classifier;
  import dec_pkg::*;

  typedef struct {
    logic [63:0] ba, bb, ka, kb;
    logic        last;
  } word_beat_t;

  typedef struct {
    cls_t       cls;
    logic [8:0] span;
    logic [7:0] c1, d1, c2, d2;
    logic       neg;
  } excitation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] in_bra_alpha_word = '0, in_bra_beta_word = '0;
  logic [63:0] in_ket_alpha_word = '0, in_ket_beta_word = '0;
  logic in_last_word = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_excitation_class;
  logic [8:0] out_excitation_distance;
  logic [7:0] out_create_first, out_destroy_first, out_create_second, out_destroy_second;
  logic out_sign_negative;

  determinant_excitation_classifier uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_beat_t  pending_words[$];
  excitation_t expected_excitations[$];
  int mismatches = 0;
  bit calm = 1'b0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  // classifier state
  int unsigned w_idx;
  bit par_a, par_b;
  int unsigned n_diff;
  int unsigned n_ca, n_cb, n_da, n_db;
  bit          sl_spin[4];
  logic [7:0]  sl_orb[4];
  bit          sl_par[4];

  function automatic int unsigned popcount(logic [63:0] x);
    int unsigned n = 0;
    for (int i = 0; i < 64; i++) n += x[i];
    return n;
  endfunction

  function automatic int unsigned clip3(int unsigned s);
    return s > 3 ? 3 : s;
  endfunction

  function automatic void clear_pair();
    w_idx = 0; par_a = 0; par_b = 0; n_diff = 0;
    n_ca = 0; n_cb = 0; n_da = 0; n_db = 0;
    for (int i = 0; i < 4; i++) begin
      sl_spin[i] = 0; sl_orb[i] = 0; sl_par[i] = 0;
    end
  endfunction

  function automatic void capture(logic [63:0] bits, bit spin, logic [63:0] ketw,
                                  int unsigned base, int unsigned used, bit par0);
    for (int p = 0; p < 64 && used < 2; p++) begin
      if (bits[p]) begin
        sl_spin[base+used] = spin;
        sl_orb[base+used] = 8'((w_idx & 3) * 64 + p);
        sl_par[base+used] = par0 ^ 1'(popcount(ketw & ((64'd1 << p) - 64'd1)));
        used++;
      end
    end
  endfunction

  function automatic void scan_word(word_beat_t w);
    logic [63:0] ua, ub;
    int unsigned used;
    bit fin;
    excitation_t e;
    int unsigned sa, sd;
    logic [7:0] a, b, i, j;
    ua = w.ba ^ w.ka;
    ub = w.bb ^ w.kb;
    fin = w.last || w_idx >= WORDS - 1;
    n_diff += popcount(ua) + popcount(ub);
    used = clip3(n_ca + n_cb);
    capture(ua & w.ba, 0, w.ka, 0, used > 2 ? 2 : used, par_a);
    n_ca = clip3(n_ca + popcount(ua & w.ba));
    used = clip3(n_ca + n_cb);
    capture(ub & w.bb, 1, w.kb, 0, used > 2 ? 2 : used, par_b);
    n_cb = clip3(n_cb + popcount(ub & w.bb));
    used = clip3(n_da + n_db);
    capture(ua & w.ka, 0, w.ka, 2, used > 2 ? 2 : used, par_a);
    n_da = clip3(n_da + popcount(ua & w.ka));
    used = clip3(n_da + n_db);
    capture(ub & w.kb, 1, w.kb, 2, used > 2 ? 2 : used, par_b);
    n_db = clip3(n_db + popcount(ub & w.kb));
    par_a ^= 1'(popcount(w.ka));
    par_b ^= 1'(popcount(w.kb));
    if (!fin) begin
      w_idx = (w_idx + 1) & 7;
      return;
    end
    e.cls = CLS_HIGHER; e.c1 = 0; e.d1 = 0; e.c2 = 0; e.d2 = 0; e.neg = 0;
    e.span = 9'(n_diff / 2);
    if (n_ca == 0 && n_cb == 0 && n_da == 0 && n_db == 0) begin
      e.cls = CLS_IDENT;
    end else if (n_ca != n_da || n_cb != n_db || n_ca + n_cb > 2) begin
      e.cls = CLS_HIGHER;
    end else if (n_ca + n_cb == 1) begin
      e.cls = (n_ca == 1) ? CLS_SGL_A : CLS_SGL_B;
      e.c1 = sl_orb[0]; e.d1 = sl_orb[2];
      e.neg = sl_par[0] ^ sl_par[2];
    end else if (n_ca == 1) begin
      sa = sl_spin[0] == 0 ? 0 : 1;
      sd = sl_spin[2] == 0 ? 2 : 3;
      e.cls = CLS_DBL_AB;
      e.c1 = sl_orb[sa]; e.c2 = sl_orb[sa^1];
      e.d1 = sl_orb[sd]; e.d2 = sl_orb[sd^1];
      e.neg = sl_par[0] ^ sl_par[1] ^ sl_par[2] ^ sl_par[3];
    end else begin
      a = sl_orb[0]; b = sl_orb[1]; i = sl_orb[2]; j = sl_orb[3];
      e.cls = (n_ca == 2) ? CLS_DBL_AA : CLS_DBL_BB;
      e.c1 = a; e.c2 = b; e.d1 = i; e.d2 = j;
      e.neg = sl_par[0] ^ sl_par[1] ^ sl_par[2] ^ sl_par[3]
              ^ (i < b) ^ (a < b) ^ (i < j) ^ (a < j);
    end
    expected_excitations = {expected_excitations, e};
    clear_pair();
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sparse64();
    logic [63:0] x = '0;
    int n = $urandom_range(0, 12);
    for (int k = 0; k < n; k++) x[$urandom_range(0, 63)] = 1'b1;
    return x;
  endfunction

  function automatic logic [63:0] flip_bits(logic [63:0] x, int n);
    for (int k = 0; k < n; k++) x[$urandom_range(0, 63)] ^= 1'b1;
    return x;
  endfunction

  task automatic add_word(logic [63:0] ba, bb, ka, kb, logic last);
    word_beat_t w;
    w.ba = ba; w.bb = bb; w.ka = ka; w.kb = kb; w.last = last;
    pending_words = {pending_words, w};
  endtask

  // move one alpha/beta electron within a word, keeping counts balanced
  function automatic logic [63:0] move_electron(logic [63:0] x);
    int s, d;
    for (int t = 0; t < 20; t++) begin
      s = $urandom_range(0, 63); d = $urandom_range(0, 63);
      if (x[s] && !x[d]) begin
        x[s] = 1'b0; x[d] = 1'b1;
        return x;
      end
    end
    return x;
  endfunction

  task automatic add_pair(int nwords, int moves_a, int moves_b, bit noisy);
    logic [63:0] ka[4], kb[4], ba[4], bb[4];
    int w;
    for (w = 0; w < nwords; w++) begin
      ka[w] = ($urandom_range(0, 3) == 0) ? rand64() : sparse64();
      kb[w] = ($urandom_range(0, 3) == 0) ? rand64() : sparse64();
      ba[w] = ka[w]; bb[w] = kb[w];
    end
    for (int m = 0; m < moves_a; m++) begin
      w = $urandom_range(0, nwords - 1);
      ba[w] = move_electron(ba[w]);
    end
    for (int m = 0; m < moves_b; m++) begin
      w = $urandom_range(0, nwords - 1);
      bb[w] = move_electron(bb[w]);
    end
    if (noisy) begin
      w = $urandom_range(0, nwords - 1);
      if ($urandom_range(0, 1)) ba[w] = flip_bits(ba[w], 1);
      else bb[w] = flip_bits(bb[w], $urandom_range(1, 3));
    end
    for (w = 0; w < nwords; w++)
      add_word(ba[w], bb[w], ka[w], kb[w],
               (w == nwords - 1) ? ((nwords == WORDS) ? $urandom_range(0, 1) : 1'b1)
                                 : ($urandom_range(0, 30) == 0));
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_excitations.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        scan_word('{in_bra_alpha_word, in_bra_beta_word, in_ket_alpha_word,
                    in_ket_beta_word, in_last_word});
      end
      if (pending_words.size() != 0 && !hold_sender &&
          (calm || $urandom_range(0, 99) >= 18)) begin
        word_beat_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_bra_alpha_word <= w.ba;
        in_bra_beta_word <= w.bb;
        in_ket_alpha_word <= w.ka;
        in_ket_beta_word <= w.kb;
        in_last_word <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_excitations.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: class %0d", out_excitation_class);
        end else begin
          excitation_t e;
          e = expected_excitations.pop_front();
          if (out_excitation_class !== e.cls || out_excitation_distance !== e.span ||
              out_create_first !== e.c1 || out_destroy_first !== e.d1 ||
              out_create_second !== e.c2 || out_destroy_second !== e.d2 ||
              out_sign_negative !== e.neg) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp cls %0d dist %0d c %0d/%0d d %0d/%0d neg %0d,",
                        " got cls %0d dist %0d c %0d/%0d d %0d/%0d neg %0d"},
                       e.cls, e.span, e.c1, e.c2, e.d1, e.d2, e.neg,
                       out_excitation_class, out_excitation_distance, out_create_first,
                       out_create_second, out_destroy_first, out_destroy_second,
                       out_sign_negative);
          end
        end
      end
      out_ready <= calm || $urandom_range(0, 99) >= 18;
    end
  end

  initial begin
    clear_pair();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // identical, extremes of fields
    add_word('0, '0, '0, '0, 1'b1);
    add_word('1, '1, '1, '1, 1'b1);
    add_word('1, '1, '0, '0, 1'b0);
    add_word('1, '1, '0, '0, 1'b0);
    add_word('1, '1, '0, '0, 1'b0);
    add_word('1, '1, '0, '0, 1'b0);
    // single alpha, then a beta pair with unequal electron counts
    add_word(64'h2, '0, 64'h1, '0, 1'b1);
    add_word('0, 64'h8000_0000_0000_0000, '0, 64'h5, 1'b1);
    // across words: single alpha at word 3 with missing end mark
    add_word(64'hF, 64'h3, 64'hF, 64'h3, 1'b0);
    add_word(64'h0, 64'h0, 64'h0, 64'h0, 1'b0);
    add_word(64'h0, 64'h0, 64'h0, 64'h0, 1'b0);
    add_word(64'h8000_0000_0000_0001, 64'h0, 64'h1_0000_0001, 64'h0, 1'b0);
    // double AA, BB, AB, higher, unbalanced, spin flip
    add_word(64'h30, '0, 64'h3, '0, 1'b1);
    add_word(64'h5, '0, 64'hA, '0, 1'b1);
    add_word('0, 64'h90, '0, 64'h9, 1'b1);
    add_word(64'h4, 64'h8, 64'h1, 64'h2, 1'b1);
    add_word(64'h70, '0, 64'h7, '0, 1'b1);
    add_word(64'h3, '0, 64'h1, '0, 1'b1);
    add_word(64'h2, '0, '0, 64'h2, 1'b1);
    add_word(64'hF0F0, 64'h3, 64'h0F0F, 64'h3, 1'b0);
    add_word(64'h1, 64'h0, 64'h2, 64'h0, 1'b1);
    wait_drained();
    hold_sender = 1'b1;
    repeat (5) @(posedge clk);
    hold_sender = 1'b0;
    for (int p = 0; p < 350; p++) begin
      if (p == 120) calm = 1'b1;
      if (p == 180) calm = 1'b0;
      if (p == 200) begin
        wait_drained();
        hold_sender = 1'b1;
        repeat (3) @(posedge clk);
        hold_sender = 1'b0;
      end
      if ($urandom_range(0, 9) == 0)
        add_word(rand64(), rand64(), rand64(), rand64(), $urandom_range(0, 1));
      else
        add_pair($urandom_range(1, WORDS), $urandom_range(0, 2), $urandom_range(0, 2),
                 $urandom_range(0, 7) == 0);
      while (pending_words.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_excitations.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
